### sv/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette lookup package
// Shared sizes, types, status and function codes and small helper functions
// for the palette color lookup and insert block.
// ----------------------------------------------------------------------------
package plt_pkg;

	localparam int ENTRIES  = 256;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int COLOR_W  = 32;
	localparam int EXT_W    = 8;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [EXT_W-1:0]   ext_idx_t;

	localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_INSERTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_WRITTEN  = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_LOOKUP = 1'b0,
		FUNC_WRITE  = 1'b1
	} func_t;

	// Request from the sequencer to the palette memory.
	typedef struct packed {
		logic   we;
		idx_t   waddr;
		color_t wdata;
		idx_t   raddr;
	} mem_req_t;

	typedef struct packed {
		ext_idx_t palette_index;
		status_t  status;
	} res_t;

	// Entry index from the port to a table address.
	function automatic idx_t to_addr(ext_idx_t x);
		logic [IDX_W+EXT_W-1:0] w;
		w = {{IDX_W{1'b0}}, x};
		return w[IDX_W-1:0];
	endfunction

	// Table address to the reported index, keeping the low bits.
	function automatic ext_idx_t to_ext(idx_t x);
		logic [IDX_W+EXT_W-1:0] w;
		w = {{EXT_W{1'b0}}, x};
		return w[EXT_W-1:0];
	endfunction

	function automatic logic in_table(ext_idx_t x);
		return ({{(32-EXT_W){1'b0}}, x} < 32'(ENTRIES));
	endfunction

endpackage

### sv/plt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette lookup channel interfaces
// Valid/ready channels for the request words and the result words.
// ----------------------------------------------------------------------------
interface plt_req_if import plt_pkg::*; ();
	logic     valid;
	logic     ready;
	logic     func;
	color_t   color;
	ext_idx_t entry_index;

	modport source (output valid, output func, output color, output entry_index,
		input ready);
	modport sink (input valid, input func, input color, input entry_index,
		output ready);
endinterface

interface plt_rsp_if import plt_pkg::*; ();
	logic     valid;
	logic     ready;
	ext_idx_t palette_index;
	logic [1:0] status;

	modport source (output valid, output palette_index, output status, input ready);
	modport sink (input valid, input palette_index, input status, output ready);
endinterface

### sv/plt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single port pair RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module plt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/plt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette lookup sequencer
// Walks the palette one entry a cycle through a single compare unit, tracks
// the first free entry and issues the final write and the result.
// ----------------------------------------------------------------------------
module plt_seq import plt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     func,
	input  color_t   color,
	input  ext_idx_t entry_index,
	input  color_t   rd_color,
	output logic     idle,
	output mem_req_t mem,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;
	color_t color_q;
	idx_t   cmp_idx_s1;
	logic   free_found_q;
	idx_t   free_idx_q;
	res_t   res_q;

	logic hit;
	logic is_free;
	logic last;
	logic ins_found;
	idx_t ins_idx;

	assign hit       = (rd_color == color_q);
	assign is_free   = (rd_color == '0) && (cmp_idx_s1 != '0);
	assign last      = (cmp_idx_s1 == LAST_IDX);
	assign ins_found = free_found_q || is_free;
	assign ins_idx   = free_found_q ? free_idx_q : cmp_idx_s1;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_comb begin
		mem.we    = 1'b0;
		mem.waddr = ins_idx;
		mem.wdata = color_q;
		mem.raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (start && func == FUNC_WRITE && in_table(entry_index)) begin
					mem.we    = 1'b1;
					mem.waddr = to_addr(entry_index);
					mem.wdata = color;
				end
			end
			S_SCAN: begin
				mem.raddr = idx_t'(cmp_idx_s1 + 1'b1);
				mem.we    = last && !hit && ins_found;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmp_idx_s1   <= '0;
			free_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (func == FUNC_WRITE) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
						cmp_idx_s1   <= '0;
						free_found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (hit || last) begin
						state_q <= S_DONE;
					end else begin
						cmp_idx_s1 <= idx_t'(cmp_idx_s1 + 1'b1);
						if (is_free && !free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					color_q <= color;
					res_q   <= '{palette_index: entry_index, status: ST_WRITTEN};
				end
			end
			S_SCAN: begin
				if (is_free && !free_found_q) begin
					free_idx_q <= cmp_idx_s1;
				end
				if (hit) begin
					res_q <= '{palette_index: to_ext(cmp_idx_s1), status: ST_HIT};
				end else if (last && ins_found) begin
					res_q <= '{palette_index: to_ext(ins_idx), status: ST_INSERTED};
				end else if (last) begin
					res_q <= '{palette_index: to_ext(LAST_IDX), status: ST_FULL};
				end
			end
			default: begin
			end
		endcase
	end

	// A write to the palette comes only from a direct write or a scan's end.
	a_write_origin: assert property (@(posedge clk) disable iff (!arst_n)
		mem.we |-> (state_q == S_IDLE && start) || (state_q == S_SCAN && last))
		else $error("palette write outside a write word or a scan end");

	// Entry zero is never taken as a free entry.
	a_free_not_zero: assert property (@(posedge clk) disable iff (!arst_n)
		free_found_q |-> free_idx_q != '0)
		else $error("entry zero recorded as free");

	// A hit result follows a real match on the compared entry.
	a_hit_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit) |=> (state_q == S_DONE && res_q.status == ST_HIT))
		else $error("match did not produce a hit result");

endmodule

### sv/palette_color_lookup_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color lookup and insert
// Searches a palette of colors for a match, inserts misses into the first
// free entry, and accepts direct writes that preset single entries.
// ----------------------------------------------------------------------------
// A write word needs no scan: its result goes through the sequencer's result
// register to the output register. In a lookup one palette entry is compared
// per cycle through the single read port of the palette memory, and the scan
// stops at the first match or after the last entry.
// One word is in work at a time; the next word is taken once the result has
// moved to the output register. Reset clears all entries at once.
// ----------------------------------------------------------------------------
module palette_color_lookup_insert import plt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	plt_req_if.sink  req,
	plt_rsp_if.source rsp
);

	// Each entry carries a valid bit; an entry never written reads as zero,
	// which is the cleared palette without a clearing pass over the memory.
	logic [ENTRIES-1:0] valid_q;
	logic               vld_rd_s1;
	color_t             rdata;
	color_t             rd_color;

	mem_req_t mem;
	logic     start;
	logic     idle;
	logic     res_valid;
	logic     res_ready;
	res_t     res;

	logic out_vld_q;
	res_t out_res_q;

	assign req.ready = idle;
	assign start     = req.valid && idle;

	plt_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (mem.we) begin
				valid_q[mem.waddr] <= 1'b1;
			end
			vld_rd_s1 <= valid_q[mem.raddr];
		end
	end

	assign rd_color = vld_rd_s1 ? rdata : '0;

	// The sequencer runs the scan and holds the finished result until the
	// output register can take it.
	plt_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (req.func),
		.color       (req.color),
		.entry_index (req.entry_index),
		.rd_color    (rd_color),
		.idle        (idle),
		.mem         (mem),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: parts the result side from the sequencer so a new
	// word can be taken while a result still waits.
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.palette_index = out_res_q.palette_index;
	assign rsp.status        = out_res_q.status;

	// Once a word is taken the block is busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req.ready)
		else $error("request taken again right after acceptance");

	// A result word that is not taken stays offered.
	a_rsp_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("result word dropped before it was taken");

	// A waiting result word keeps its contents.
	a_rsp_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(out_res_q))
		else $error("result word changed while waiting");

endmodule

### tb/palette_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette lookup checker
// Watches the request and result channels, keeps a shadow palette, predicts
// the result of every accepted request word and compares it with the result
// words in order.
// ----------------------------------------------------------------------------
module palette_lookup_checker import plt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	plt_req_if   req,
	plt_rsp_if   rsp,
	output int   errors,
	output int   pending,
	output int   hits,
	output int   inserts,
	output int   fulls,
	output int   writes
);

	color_t shadow_palette [ENTRIES];
	res_t   expected_results [$];

	// Prints one line per mismatch and counts it.
	task automatic report(string what);
		$display("%0t ns mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic res_t lookup_or_insert(func_t fn, color_t color, ext_idx_t widx);
		res_t r;
		int   slot;
		if (fn == FUNC_WRITE) begin
			if (int'(widx) < ENTRIES)
				shadow_palette[widx] = color;
			r.palette_index = widx;
			r.status        = ST_WRITTEN;
			writes++;
			return r;
		end
		// First match from entry 0, zero included.
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && shadow_palette[i] == color)
				slot = i;
		if (slot >= 0) begin
			r.palette_index = ext_idx_t'(slot);
			r.status        = ST_HIT;
			hits++;
			return r;
		end
		// Miss: first free entry from 1, entry 0 is never handed out.
		for (int i = 1; i < ENTRIES; i++)
			if (slot < 0 && shadow_palette[i] == '0)
				slot = i;
		if (slot >= 0) begin
			shadow_palette[slot] = color;
			r.palette_index = ext_idx_t'(slot);
			r.status        = ST_INSERTED;
			inserts++;
		end else begin
			r.palette_index = ext_idx_t'(ENTRIES - 1);
			r.status        = ST_FULL;
			fulls++;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			foreach (shadow_palette[i])
				shadow_palette[i] = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			// Results first: a result never belongs to a request taken at the same edge.
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("result index %0d status %0d with nothing expected",
						rsp.palette_index, rsp.status));
				end else begin
					want = expected_results.pop_front();
					if (rsp.palette_index !== want.palette_index)
						report($sformatf("palette_index %0d, expected %0d",
							rsp.palette_index, want.palette_index));
					if (rsp.status !== want.status)
						report($sformatf("status %0d, expected %0d (index %0d)",
							rsp.status, want.status, want.palette_index));
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(lookup_or_insert(func_t'(req.func), req.color,
					req.entry_index));
			pending <= expected_results.size();
		end
	end

endmodule

### tb/tb_palette_color_lookup_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette color lookup and insert testbench
// Drives lookup and write words into the palette block, with a directed
// opening and random phases under several idle and stall patterns. A checker
// beside the block predicts every result word and compares it in order.
// ----------------------------------------------------------------------------
module tb_palette_color_lookup_insert;
	import plt_pkg::*;

	// Kinds of random traffic. Fill mostly sends new colors so the table runs
	// full; churn frees entries with zero writes; blend sits in between.
	typedef enum int {
		MIX_FILL,
		MIX_CHURN,
		MIX_BLEND
	} traffic_mix_t;

	localparam int POOL_SIZE   = 32;
	localparam int HOLD_CYCLES = 400;
	localparam int TIMEOUT_NS  = 50_000_000;

	logic clk = 1'b0;
	logic arst_n;

	plt_req_if req_ch ();
	plt_rsp_if rsp_ch ();

	int errors;
	int pending;
	int hits;
	int inserts;
	int fulls;
	int writes;

	// Pacing knobs. The receiver reads rx_stall_pct and hold_req at the clock
	// edge, so the stimulus updates them with nonblocking assignments.
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_req     = 0;
	int words_sent   = 0;

	// Colors sent recently; looking them up again makes hits likely.
	color_t color_pool [POOL_SIZE];
	int     pool_wr = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	palette_color_lookup_insert u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	palette_lookup_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending),
		.hits    (hits),
		.inserts (inserts),
		.fulls   (fulls),
		.writes  (writes)
	);

	// Offers one word after a random idle gap and returns once it has been
	// taken. The valid stays high when the next word follows with no gap.
	task automatic send_word(func_t fn, color_t color, ext_idx_t widx);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= fn;
		req_ch.color       <= color;
		req_ch.entry_index <= widx;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		if (color != '0) begin
			color_pool[pool_wr] = color;
			pool_wr = (pool_wr + 1) % POOL_SIZE;
		end
	endtask

	// Lowers valid and waits until every expected result word has come. The
	// first edge lets the checker count a word taken at the current edge.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic make_word(traffic_mix_t mix, output func_t fn, output color_t color,
		output ext_idx_t widx);
		int fresh_pct;
		int pool_pct;
		int zero_wr_pct;
		int roll;
		case (mix)
			MIX_FILL: begin
				fresh_pct = 85; pool_pct = 10; zero_wr_pct = 50;
			end
			MIX_CHURN: begin
				fresh_pct = 20; pool_pct = 30; zero_wr_pct = 60;
			end
			default: begin
				fresh_pct = 35; pool_pct = 30; zero_wr_pct = 40;
			end
		endcase
		// The index only matters for writes; lookups carry noise there.
		if ($urandom_range(9) == 0)
			widx = $urandom_range(1) ? ext_idx_t'(ENTRIES - 1) : '0;
		else
			widx = ext_idx_t'($urandom());
		roll = $urandom_range(99);
		if (roll < fresh_pct) begin
			fn    = FUNC_LOOKUP;
			color = $urandom();
		end else if (roll < fresh_pct + pool_pct) begin
			fn    = FUNC_LOOKUP;
			color = color_pool[$urandom_range(POOL_SIZE - 1)];
		end else if (roll < fresh_pct + pool_pct + 3) begin
			fn    = FUNC_LOOKUP;
			color = '0;
		end else begin
			// Writes free entries, plant duplicates of known colors, or preset.
			fn   = FUNC_WRITE;
			roll = $urandom_range(99);
			if (roll < zero_wr_pct)
				color = '0;
			else if (roll < zero_wr_pct + 25)
				color = color_pool[$urandom_range(POOL_SIZE - 1)];
			else
				color = $urandom();
		end
	endtask

	task automatic run_phase(int count, traffic_mix_t mix, int tx_pct, int rx_pct);
		func_t    fn;
		color_t   color;
		ext_idx_t widx;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		repeat (count) begin
			make_word(mix, fn, color, widx);
			send_word(fn, color, widx);
		end
		drain();
	endtask

	// Result side: random stalls, plus one long counted hold-off on request.
	initial begin
		int hold_ack;
		int hold_left;
		hold_ack  = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ack != hold_req) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	initial begin
		foreach (color_pool[i])
			color_pool[i] = $urandom();
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= FUNC_LOOKUP;
		req_ch.color       <= '0;
		req_ch.entry_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. The table starts all zero, so a zero lookup hits
		// entry 0, and new colors go to entries 1, 2, 3 in turn.
		send_word(FUNC_LOOKUP, 32'h0000_0000, 8'h00);
		send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'hFF);
		send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00);
		send_word(FUNC_LOOKUP, 32'h0000_0001, 8'h55);
		send_word(FUNC_LOOKUP, 32'h8000_0000, 8'hAA);
		// Once entry 0 holds a color, a zero lookup finds the first free entry
		// instead, as an ordinary hit.
		send_word(FUNC_WRITE, 32'hA5A5_A5A5, 8'h00);
		send_word(FUNC_LOOKUP, 32'h0000_0000, 8'h00);
		send_word(FUNC_LOOKUP, 32'hA5A5_A5A5, 8'h00);
		// The last entry can be preset and found.
		send_word(FUNC_WRITE, 32'h5A5A_5A5A, 8'hFF);
		send_word(FUNC_LOOKUP, 32'h5A5A_5A5A, 8'h00);
		// Freeing an entry makes it the next place for an insert.
		send_word(FUNC_WRITE, 32'h0000_0000, 8'h02);
		send_word(FUNC_LOOKUP, 32'h1234_5678, 8'h00);
		// With two equal entries the lower index wins.
		send_word(FUNC_WRITE, 32'hFFFF_FFFF, 8'h03);
		send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00);
		send_word(FUNC_WRITE, 32'h0000_0000, 8'h01);
		send_word(FUNC_LOOKUP, 32'hFFFF_FFFF, 8'h00);
		send_word(FUNC_WRITE, 32'h0000_0000, 8'h00);
		send_word(FUNC_WRITE, 32'h7FFF_FFFF, 8'h80);
		send_word(FUNC_LOOKUP, 32'h7FFF_FFFF, 8'h00);
		send_word(FUNC_LOOKUP, 32'hFFFF_FFFE, 8'hFF);
		send_word(FUNC_WRITE, 32'h0000_0000, 8'hFF);
		drain();

		// Random phases. The first one runs the table full, so later misses
		// report the last index with the full status until writes free room.
		run_phase(350, MIX_FILL, 0, 0);
		run_phase(220, MIX_CHURN, 78, 0);
		run_phase(220, MIX_BLEND, 0, 78);
		run_phase(220, MIX_FILL, 36, 36);

		// Back pressure: the receiver holds off for a long stretch while the
		// sender keeps offering words, so the block fills and stops taking
		// requests. Afterwards traffic flows freely again.
		rx_stall_pct <= 0;
		hold_req     <= hold_req + 1;
		run_phase(130, MIX_BLEND, 0, 0);

		// Let any stray result word show up before the verdict.
		repeat (ENTRIES + 8) @(posedge clk);

		$display("Sent %0d words: %0d hits, %0d inserts, %0d full, %0d direct writes.",
			words_sent, hits, inserts, fulls, writes);
		$display("Pacing covered free flow, sender gaps, receiver stalls, both, and a long hold-off.");
		if (errors == 0) begin
			$display("tb_palette_color_lookup_insert: clean");
		end else begin
			$display("tb_palette_color_lookup_insert: errors");
		end
		$finish;
	end

	// Safety net for a hung handshake or a missing result word.
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d result words outstanding.", pending);
		$display("tb_palette_color_lookup_insert: errors");
		$finish;
	end

endmodule
